### rtl/core/mgif_pkg.sv
// shared constants, widths and helper types for the median / gaussian interval filter
// no dependencies; imported by every module of the block

package mgif_pkg;

    // window and sample geometry
    localparam int WINDOW_TAPS  = 11;
    localparam int SAMPLE_WIDTH = 32;

    // fixed field widths
    localparam int FREQ_W   = 32;
    localparam int WEIGHT_W = 16;
    localparam int OUT_W    = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int N_WEIGHTS = 6;
    localparam int DIST_W   = 3;

    // microseconds per second and its width
    localparam int US_W = 20;
    localparam logic [US_W-1:0] US_PER_S = US_W'(1000000);

    // derived datapath widths
    localparam int K_W     = $clog2(WINDOW_TAPS);
    localparam int FILL_W  = $clog2(WINDOW_TAPS + 1);
    localparam int TAPP_W  = SAMPLE_WIDTH + WEIGHT_W;
    localparam int ACC_W   = TAPP_W + $clog2(WINDOW_TAPS);
    localparam int HALF_W  = (ACC_W + 1) / 2;
    localparam int PART_W  = HALF_W + US_W;
    localparam int PROD_W  = ACC_W + US_W;
    localparam int QNUM_W  = PROD_W - WEIGHT_W;
    localparam int DCNT_W  = $clog2(QNUM_W + 1);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_FREQ = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_W_CENTER  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_W_OFF1    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_W_OFF2    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_W_OFF3    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_W_OFF4    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_W_OFF5    = 3'd6;

    // reset values of the registers
    localparam logic [FREQ_W-1:0]   RST_FREQ      = FREQ_W'(10000000);
    localparam logic [WEIGHT_W-1:0] RST_W_CENTER  = WEIGHT_W'(14294);
    localparam logic [WEIGHT_W-1:0] RST_W_OFF1    = WEIGHT_W'(12319);
    localparam logic [WEIGHT_W-1:0] RST_W_OFF2    = WEIGHT_W'(7884);
    localparam logic [WEIGHT_W-1:0] RST_W_OFF3    = WEIGHT_W'(3748);
    localparam logic [WEIGHT_W-1:0] RST_W_OFF4    = WEIGHT_W'(1323);
    localparam logic [WEIGHT_W-1:0] RST_W_OFF5    = WEIGHT_W'(347);

    typedef logic [SAMPLE_WIDTH-1:0] t_sample;

    // divider status back to the sequencer
    typedef struct packed {
        logic             done;
        logic [OUT_W-1:0] quot;
    } t_div_stat;

    // distance of a window position from the middle, capped at the outer weight
    function automatic logic [DIST_W-1:0] tap_dist(input logic [K_W-1:0] k);
        logic [K_W-1:0] c;
        logic [K_W-1:0] d;
        c = K_W'(WINDOW_TAPS / 2);
        d = (k >= c) ? (k - c) : (c - k);
        if (d > K_W'(N_WEIGHTS - 1)) begin
            d = K_W'(N_WEIGHTS - 1);
        end
        return DIST_W'(d);
    endfunction

endpackage

### rtl/core/median_gaussian_interval_filter.sv
// top level: median of five into an eleven-cell window, gaussian sum, tick to us conversion
// depends on mgif_pkg, mgif_median, mgif_cell, mgif_div
//
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_ready   i_sample_a .. i_sample_e
//  output    out        o_out_valid / i_out_ready o_interval_us
//  config    in         i_cfg_we (no wait)        i_cfg_idx, i_cfg_wdata
//
// a beat that leaves the window short of full only shifts it and gives no result
// a beat that gives a result then runs the tap rotation through the cell chain,
// the split multiply by 10^6, the bit-serial divider (start, 56 quotient bits, done)
// and the load of the output register
// the result sits in an output register, so the input side reopens while it waits
// synchronous active-low reset clears control, fill count and registers to defaults

module median_gaussian_interval_filter
    import mgif_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [SAMPLE_WIDTH-1:0] i_sample_a,
    input  logic [SAMPLE_WIDTH-1:0] i_sample_b,
    input  logic [SAMPLE_WIDTH-1:0] i_sample_c,
    input  logic [SAMPLE_WIDTH-1:0] i_sample_d,
    input  logic [SAMPLE_WIDTH-1:0] i_sample_e,

    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [OUT_W-1:0]        o_interval_us,

    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_wdata
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_MAC    = 7'b0000010,
        ST_MUL_LO = 7'b0000100,
        ST_MUL_HI = 7'b0001000,
        ST_DIV_GO = 7'b0010000,
        ST_DIV    = 7'b0100000,
        ST_OUT    = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // configuration registers
    logic [FREQ_W-1:0]   r_freq;
    logic [WEIGHT_W-1:0] r_weight [N_WEIGHTS];

    // control and datapath registers
    logic [FILL_W-1:0]   r_fill;
    logic [K_W-1:0]      r_tap;
    logic [ACC_W-1:0]    r_acc;
    logic [PROD_W-1:0]   r_prod;
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_data;

    logic                w_in_beat;
    logic                w_shift;
    logic                w_last_tap;
    logic                w_out_load;
    t_sample             w_samp [5];
    t_sample             w_med;
    t_sample             w_cell_in  [WINDOW_TAPS];
    t_sample             w_cell_out [WINDOW_TAPS];
    logic [TAPP_W-1:0]   w_tap_prod;
    logic [HALF_W-1:0]   w_mul_sel;
    logic [PART_W-1:0]   w_part;
    t_div_stat           w_div;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq      <= RST_FREQ;
            r_weight[0] <= RST_W_CENTER;
            r_weight[1] <= RST_W_OFF1;
            r_weight[2] <= RST_W_OFF2;
            r_weight[3] <= RST_W_OFF3;
            r_weight[4] <= RST_W_OFF4;
            r_weight[5] <= RST_W_OFF5;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TICK_FREQ: r_freq      <= i_cfg_wdata[FREQ_W-1:0];
                CFG_W_CENTER:  r_weight[0] <= i_cfg_wdata[WEIGHT_W-1:0];
                CFG_W_OFF1:    r_weight[1] <= i_cfg_wdata[WEIGHT_W-1:0];
                CFG_W_OFF2:    r_weight[2] <= i_cfg_wdata[WEIGHT_W-1:0];
                CFG_W_OFF3:    r_weight[3] <= i_cfg_wdata[WEIGHT_W-1:0];
                CFG_W_OFF4:    r_weight[4] <= i_cfg_wdata[WEIGHT_W-1:0];
                CFG_W_OFF5:    r_weight[5] <= i_cfg_wdata[WEIGHT_W-1:0];
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- median
    assign w_samp[0] = i_sample_a;
    assign w_samp[1] = i_sample_b;
    assign w_samp[2] = i_sample_c;
    assign w_samp[3] = i_sample_d;
    assign w_samp[4] = i_sample_e;

    mgif_median u_median (
        .i_samp (w_samp),
        .o_med  (w_med)
    );

    // ---------------------------------------------------------------- window chain
    // cell 0 holds the oldest median; a new median enters at the far end,
    // and during the sum the chain rotates so each entry passes cell 0 once
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_beat  = i_in_valid && o_in_ready;
    assign w_shift    = w_in_beat || (r_state == ST_MAC);

    always_comb begin
        for (int i = 0; i < WINDOW_TAPS - 1; i++) begin
            w_cell_in[i] = w_cell_out[i + 1];
        end
        w_cell_in[WINDOW_TAPS-1] = (r_state == ST_MAC) ? w_cell_out[0] : w_med;
    end

    for (genvar g = 0; g < WINDOW_TAPS; g++) begin : g_cell
        mgif_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_data  (w_cell_in[g]),
            .o_data  (w_cell_out[g])
        );
    end

    // ---------------------------------------------------------------- arithmetic
    assign w_tap_prod = w_cell_out[0] * r_weight[tap_dist(r_tap)];
    assign w_last_tap = (r_tap == K_W'(WINDOW_TAPS - 1));

    // times 10^6 in two halves of the accumulator
    assign w_mul_sel = (r_state == ST_MUL_HI) ? HALF_W'(r_acc[ACC_W-1:HALF_W])
                                              : r_acc[HALF_W-1:0];
    assign w_part    = w_mul_sel * US_PER_S;

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_acc <= '0;
                r_tap <= '0;
            end
            ST_MAC: begin
                r_acc <= r_acc + ACC_W'(w_tap_prod);
                r_tap <= r_tap + K_W'(1);
            end
            ST_MUL_LO: r_prod <= PROD_W'(w_part);
            ST_MUL_HI: r_prod <= r_prod + (PROD_W'(w_part) << HALF_W);
            ST_DIV_GO, ST_DIV, ST_OUT: begin
                // hold
            end
        endcase
    end

    // dividing by freq * 2^16 is the same as dropping 16 bits, then dividing by freq
    mgif_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_DIV_GO),
        .i_num   (r_prod[PROD_W-1:WEIGHT_W]),
        .i_den   (r_freq),
        .o_stat  (w_div)
    );

    // ---------------------------------------------------------------- sequencer
    assign w_out_load = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_beat && (r_fill >= FILL_W'(WINDOW_TAPS - 1))) begin
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                if (w_last_tap) begin
                    n_state = ST_MUL_LO;
                end
            end
            ST_MUL_LO: n_state = ST_MUL_HI;
            ST_MUL_HI: n_state = ST_DIV_GO;
            ST_DIV_GO: n_state = ST_DIV;
            ST_DIV: begin
                if (w_div.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_beat && (r_fill < FILL_W'(WINDOW_TAPS))) begin
                r_fill <= r_fill + FILL_W'(1);
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output register, loaded from the divider's held quotient
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= w_div.quot;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_interval_us = r_out_data;

endmodule

### rtl/core/mgif_median.sv
// median of five samples by rank counting, ties broken by lane order
// depends on mgif_pkg

module mgif_median
    import mgif_pkg::*;
(
    input  t_sample i_samp [5],
    output t_sample o_med
);

    logic [2:0] w_rank [5];

    always_comb begin
        for (int i = 0; i < 5; i++) begin
            w_rank[i] = 3'd0;
            for (int j = 0; j < 5; j++) begin
                if (j != i) begin
                    w_rank[i] = w_rank[i] + 3'((i_samp[j] < i_samp[i]) ||
                                               ((j < i) && (i_samp[j] == i_samp[i])));
                end
            end
        end
    end

    // ranks form a permutation, so exactly one lane has rank two
    always_comb begin
        o_med = '0;
        for (int i = 0; i < 5; i++) begin
            if (w_rank[i] == 3'd2) begin
                o_med = o_med | i_samp[i];
            end
        end
    end

endmodule

### rtl/core/mgif_cell.sv
// one window cell: holds a median and passes it to its neighbor on shift
// depends on mgif_pkg

module mgif_cell
    import mgif_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_shift,
    input  t_sample i_data,
    output t_sample o_data
);

    t_sample r_data;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule

### rtl/core/mgif_div.sv
// restoring divider, one quotient bit per cycle, saturates to the output width
// depends on mgif_pkg

module mgif_div
    import mgif_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [QNUM_W-1:0] i_num,
    input  logic [FREQ_W-1:0] i_den,
    output t_div_stat         o_stat
);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [QNUM_W-1:0] r_num;
    logic [FREQ_W-1:0] r_rem;
    logic [OUT_W-1:0]  r_quo;
    logic              r_sat;

    logic [FREQ_W:0]   w_trial;
    logic              w_fit;
    logic [FREQ_W:0]   w_diff;

    assign w_trial = {r_rem, r_num[QNUM_W-1]};
    assign w_fit   = (w_trial >= {1'b0, i_den});
    assign w_diff  = w_trial - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == DCNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(QNUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DCNT_W'(1);
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_quo <= '0;
            r_sat <= 1'b0;
        end else if (r_busy) begin
            r_num <= {r_num[QNUM_W-2:0], 1'b0};
            r_rem <= w_fit ? w_diff[FREQ_W-1:0] : w_trial[FREQ_W-1:0];
            r_quo <= {r_quo[OUT_W-2:0], w_fit};
            // a bit pushed past the top means the quotient does not fit
            r_sat <= r_sat | r_quo[OUT_W-1];
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.quot = r_sat ? '1 : r_quo;

endmodule

### bench/median_gaussian_interval_filter_tb.sv
// testbench for median_gaussian_interval_filter: directed and random interval beats,
// results checked against an in-bench median / gaussian / tick-to-us predictor
// depends on mgif_pkg and the rtl of the block

module median_gaussian_interval_filter_tb
    import mgif_pkg::*;
();

    // predictor of the block plus the queue of smoothed intervals still owed
    class interval_scoreboard;
        logic [FREQ_W-1:0]   tick_freq;
        logic [WEIGHT_W-1:0] weight_q16 [N_WEIGHTS];
        t_sample             window [WINDOW_TAPS];
        int                  fill;
        logic [OUT_W-1:0]    expected_us [$];
        int                  errors;

        function new();
            tick_freq     = RST_FREQ;
            weight_q16[0] = RST_W_CENTER;
            weight_q16[1] = RST_W_OFF1;
            weight_q16[2] = RST_W_OFF2;
            weight_q16[3] = RST_W_OFF3;
            weight_q16[4] = RST_W_OFF4;
            weight_q16[5] = RST_W_OFF5;
            foreach (window[i]) window[i] = '0;
            fill   = 0;
            errors = 0;
        endfunction

        // register update, values masked to the register width
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            unique case (idx)
                CFG_TICK_FREQ: tick_freq     = data[FREQ_W-1:0];
                CFG_W_CENTER:  weight_q16[0] = data[WEIGHT_W-1:0];
                CFG_W_OFF1:    weight_q16[1] = data[WEIGHT_W-1:0];
                CFG_W_OFF2:    weight_q16[2] = data[WEIGHT_W-1:0];
                CFG_W_OFF3:    weight_q16[3] = data[WEIGHT_W-1:0];
                CFG_W_OFF4:    weight_q16[4] = data[WEIGHT_W-1:0];
                CFG_W_OFF5:    weight_q16[5] = data[WEIGHT_W-1:0];
                default: ;
            endcase
        endfunction

        // the median is the value with at most two below it and at least three at or below
        function t_sample median_of(t_sample v [5]);
            int lt;
            int le;
            for (int i = 0; i < 5; i++) begin
                lt = 0;
                le = 0;
                for (int j = 0; j < 5; j++) begin
                    if (v[j] < v[i]) lt++;
                    if (v[j] <= v[i]) le++;
                end
                if (lt <= 2 && le >= 3) return v[i];
            end
            return v[0];
        endfunction

        // floor(sum(w*m) * 10^6 / (freq * 2^16)), saturated to 32 bits
        function logic [OUT_W-1:0] smoothed_us();
            logic [127:0] acc;
            logic [127:0] quot;
            int           d;
            acc = '0;
            for (int i = 0; i < WINDOW_TAPS; i++) begin
                d = i - WINDOW_TAPS / 2;
                if (d < 0) d = -d;
                if (d > N_WEIGHTS - 1) d = N_WEIGHTS - 1;
                acc += 128'(window[i]) * 128'(weight_q16[d]);
            end
            if (tick_freq == '0) return '1;
            quot = (acc * 128'(US_PER_S)) / {80'd0, tick_freq, 16'd0};
            return (quot > 128'(32'hFFFF_FFFF)) ? '1 : quot[OUT_W-1:0];
        endfunction

        function void note_input(t_sample a, t_sample b, t_sample c, t_sample d, t_sample e);
            t_sample five [5];
            five = '{a, b, c, d, e};
            for (int i = 0; i < WINDOW_TAPS - 1; i++) window[i] = window[i + 1];
            window[WINDOW_TAPS - 1] = median_of(five);
            if (fill < WINDOW_TAPS) fill++;
            if (fill == WINDOW_TAPS) expected_us.insert(expected_us.size(), smoothed_us());
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        task check_result(logic [OUT_W-1:0] got);
            logic [OUT_W-1:0] want;
            if (expected_us.size() == 0) begin
                report($sformatf("interval_us %0d with nothing outstanding", got));
                return;
            end
            want = expected_us[0];
            expected_us.delete(0);
            if (got !== want) begin
                report($sformatf("interval_us got %0d want %0d", got, want));
            end
        endtask
    endclass

    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 100;   // time for a result to finish
    localparam int STALL_LIMIT   = 5000;  // cycles with no beat on either side
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 216;
    localparam int IDLE_PCT      = 87;
    localparam int BOTH_PCT      = 25;

    // index past the last register, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_in_valid    = 1'b0;
    logic                    o_in_ready;
    t_sample                 i_sample_a    = '0;
    t_sample                 i_sample_b    = '0;
    t_sample                 i_sample_c    = '0;
    t_sample                 i_sample_d    = '0;
    t_sample                 i_sample_e    = '0;
    logic                    o_out_valid;
    logic                    i_out_ready   = 1'b0;
    logic [OUT_W-1:0]        o_interval_us;
    logic                    i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx     = '0;
    logic [CFG_W-1:0]        i_cfg_wdata   = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    interval_scoreboard sb = new();

    median_gaussian_interval_filter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_sample_a    (i_sample_a),
        .i_sample_b    (i_sample_b),
        .i_sample_c    (i_sample_c),
        .i_sample_d    (i_sample_d),
        .i_sample_e    (i_sample_e),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_interval_us (o_interval_us),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // receiver: ready redrawn every cycle, one assignment per edge
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: pre-edge values of both channels, results checked before the new
    // input beat is noted; watchdog on cycles with no beat at all
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                sb.check_result(o_interval_us);
            end
            if (i_in_valid && o_in_ready) begin
                sb.note_input(i_sample_a, i_sample_b, i_sample_c, i_sample_d, i_sample_e);
            end
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("median_gaussian_interval_filter_tb: done, errors");
                $finish;
            end
        end
    end

    // one input beat; valid is left high so a back-to-back beat needs no toggle
    task automatic send_item(input t_sample a, input t_sample b, input t_sample c,
                             input t_sample d, input t_sample e);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample_a <= a;
        i_sample_b <= b;
        i_sample_c <= c;
        i_sample_d <= d;
        i_sample_e <= e;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // config write beat; enable stays high between beats of one batch
    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // whole register set; junk in the upper half of weight writes checks the masking
    task automatic apply_config(input logic [FREQ_W-1:0] freq,
                                input logic [WEIGHT_W-1:0] w0, input logic [WEIGHT_W-1:0] w1,
                                input logic [WEIGHT_W-1:0] w2, input logic [WEIGHT_W-1:0] w3,
                                input logic [WEIGHT_W-1:0] w4, input logic [WEIGHT_W-1:0] w5);
        cfg_beat(CFG_TICK_FREQ, freq);
        cfg_beat(CFG_W_CENTER, {16'($urandom()), w0});
        cfg_beat(CFG_W_OFF1,   {16'($urandom()), w1});
        cfg_beat(CFG_W_OFF2,   {16'($urandom()), w2});
        cfg_beat(CFG_W_OFF3,   {16'($urandom()), w3});
        cfg_beat(CFG_W_OFF4,   {16'($urandom()), w4});
        cfg_beat(CFG_W_OFF5,   {16'($urandom()), w5});
        cfg_beat(CFG_IDX_SPARE, $urandom());
        i_cfg_we <= 1'b0;
    endtask

    // drain owed results, then give a beat without result time to finish
    task automatic settle();
        while (sb.expected_us.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        return WEIGHT_W'($urandom());
    endfunction

    // typical interval for a beat: mostly realistic tick counts, sometimes huge or tiny
    function automatic t_sample pick_interval();
        unique case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return t_sample'($urandom_range(2_000_000, 1_000));
            6, 7:             return t_sample'($urandom());
            8:                return 32'hFFFF_FE00 + t_sample'($urandom_range(255));
            default:          return t_sample'($urandom_range(255));
        endcase
    endfunction

    // one measurement near the typical interval, with outliers now and then
    function automatic t_sample jittered(input t_sample base);
        unique case ($urandom_range(19))
            0:       return '0;
            1:       return '1;
            2:       return t_sample'($urandom());
            default: return base + t_sample'($urandom_range(511));
        endcase
    endfunction

    task automatic send_random_item();
        t_sample base;
        base = pick_interval();
        send_item(jittered(base), jittered(base), jittered(base), jittered(base),
                  jittered(base));
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset register values; the first ten beats only fill the window
        send_item('0, '0, '0, '0, '0);
        send_item('1, '1, '1, '1, '1);
        send_item(32'd1, 32'd2, 32'd3, 32'd4, 32'd5);
        send_item(32'd5, 32'd4, 32'd3, 32'd2, 32'd1);
        send_item('1, '0, '1, '0, 32'd7);
        send_item(32'd9, 32'd9, 32'd1, 32'd9, 32'd1);
        send_item(32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000);
        send_item(32'd100000, 32'd100050, 32'd99990, 32'd250000, 32'd3);
        send_item(32'd3, 32'd250000, 32'd100000, 32'd99990, 32'd100050);
        send_item(32'd10, 32'd50, 32'd40, 32'd20, 32'd30);
        // window now full: every beat from here on owes a result
        send_item('1, 32'hFFFF_FFFE, 32'hFFFF_FFFD, '0, 32'd1);
        send_item('1, '1, '1, '1, '1);
        send_item('1, '1, '1, '1, '1);
        send_item('1, '1, '1, '1, '1);
        i_in_valid <= 1'b0;
        settle();

        // one tick per second: quotient far too large, saturates
        apply_config(32'd1, RST_W_CENTER, RST_W_OFF1, RST_W_OFF2, RST_W_OFF3, RST_W_OFF4,
                     RST_W_OFF5);
        send_item(32'd1000, 32'd1001, 32'd999, 32'd1002, 32'd998);
        send_item('1, '1, '1, '1, '1);
        i_in_valid <= 1'b0;
        settle();

        // zero frequency: divide by zero saturates
        apply_config('0, RST_W_CENTER, RST_W_OFF1, RST_W_OFF2, RST_W_OFF3, RST_W_OFF4,
                     RST_W_OFF5);
        send_item(32'd20000, 32'd20001, 32'd19999, 32'd20002, 32'd19998);
        i_in_valid <= 1'b0;
        settle();

        // largest frequency with every weight at full scale
        apply_config('1, '1, '1, '1, '1, '1, '1);
        send_item('1, '1, '1, '1, '1);
        send_item('1, '0, '1, '0, '1);
        i_in_valid <= 1'b0;
        settle();

        // all weights zero: the sum vanishes whatever the window holds
        apply_config(32'd1, '0, '0, '0, '0, '0, '0);
        send_item('1, '1, '1, '1, '1);
        i_in_valid <= 1'b0;

        // random phases: new register set and new idle pattern per phase
        for (int p = 0; p < PHASES; p++) begin
            settle();
            unique case (p)
                0: apply_config($urandom_range(50_000_000, 1_000_000), RST_W_CENTER,
                                RST_W_OFF1, RST_W_OFF2, RST_W_OFF3, RST_W_OFF4, RST_W_OFF5);
                1: apply_config($urandom(), rand_weight(), rand_weight(), rand_weight(),
                                rand_weight(), rand_weight(), rand_weight());
                2: apply_config(32'd1, '1, '1, '1, '1, '1, '1);
                3: apply_config('1, rand_weight(), rand_weight(), rand_weight(),
                                rand_weight(), rand_weight(), rand_weight());
                4: apply_config($urandom_range(1000, 1), RST_W_CENTER, RST_W_OFF1,
                                RST_W_OFF2, RST_W_OFF3, RST_W_OFF4, RST_W_OFF5);
                5: apply_config($urandom_range(100_000_000, 100_000), rand_weight(),
                                rand_weight(), rand_weight(), rand_weight(), rand_weight(),
                                rand_weight());
                6: apply_config(RST_FREQ, rand_weight(), '0, rand_weight(), '1,
                                rand_weight(), '0);
                default: apply_config($urandom(), rand_weight(), rand_weight(),
                                      rand_weight(), rand_weight(), rand_weight(),
                                      rand_weight());
            endcase
            unique case (p % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = IDLE_PCT;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = IDLE_PCT;
                end
                default: begin
                    send_idle_pct  = BOTH_PCT;
                    recv_stall_pct = BOTH_PCT;
                end
            endcase
            repeat (PHASE_ITEMS) send_random_item();
            i_in_valid <= 1'b0;
        end

        settle();
        if (sb.errors == 0 && sb.expected_us.size() == 0) begin
            $display("median_gaussian_interval_filter_tb: done, clean");
        end else begin
            $display("median_gaussian_interval_filter_tb: done, errors");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/mgif_pkg.sv
rtl/core/mgif_median.sv
rtl/core/mgif_cell.sv
rtl/core/mgif_div.sv
rtl/core/median_gaussian_interval_filter.sv
bench/median_gaussian_interval_filter_tb.sv
